FILE: rtl/gft_pkg.sv
package gft_pkg;

    localparam int SIGNAL_DEPTH = 4096;
    localparam int WINDOW_DEPTH = 256;
    localparam int MAX_CHANNELS = 64;
    localparam int SAMPLE_WIDTH = 16;

    localparam int SIG_AW = $clog2(SIGNAL_DEPTH);
    localparam int WIN_AW = $clog2(WINDOW_DEPTH);
    localparam int CH_AW  = $clog2(MAX_CHANNELS);

    localparam int OP_W       = 2;
    localparam int IDX_W      = 12;
    localparam int VAL_W      = 16;
    localparam int COEF_W     = 40;
    localparam int FOLD_W     = 40;
    localparam int HOP_W      = 13;
    localparam int CHN_W      = 7;
    localparam int GL_W       = 9;
    localparam int LEN_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int TW_W       = 17;

    // quarter-wave sine polynomial, unsigned Q30
    localparam logic [30:0] SIN_C1 = 31'd1686629713;
    localparam logic [30:0] SIN_C3 = 31'd693598668;
    localparam logic [30:0] SIN_C5 = 31'd85569306;
    localparam logic [30:0] SIN_C7 = 31'd5026995;
    localparam logic [30:0] SIN_C9 = 31'd172272;

    typedef enum logic [OP_W-1:0] {
        OP_TAP    = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_FRAME  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOP        = 3'd0,
        CFG_CHANNELS   = 3'd1,
        CFG_WINDOW_LEN = 3'd2,
        CFG_SIGNAL_LEN = 3'd3,
        CFG_PHASE_MODE = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_EVAL, S_ERR, S_SETUP, S_TWGO, S_TWWAIT,
        S_CLR, S_TAPA, S_TAPB, S_TAPC, S_DFT, S_DRAIN, S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        DIV_LEN, DIV_BASE, DIV_GLH
    } t_div_job;

    typedef enum logic [1:0] {
        TW_IDLE, TW_DIV, TW_SIN
    } t_tw_state;

    typedef struct packed {
        logic signed [TW_W-1:0] sin_v;
        logic signed [TW_W-1:0] cos_v;
    } t_twiddle;

endpackage

FILE: rtl/gft_if.sv
interface gft_in_if import gft_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, op, index, value, input ready);
    modport sink   (input valid, op, index, value, output ready);
endinterface

interface gft_out_if import gft_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CH_AW-1:0]         channel;
    logic signed [COEF_W-1:0] coef_re;
    logic signed [COEF_W-1:0] coef_im;
    logic                     last;
    logic                     status;

    modport source (output valid, channel, coef_re, coef_im, last, status, input ready);
    modport sink   (input valid, channel, coef_re, coef_im, last, status, output ready);
endinterface

FILE: rtl/gabor_frame_transform.sv
// Channel   Dir  Payload                                   Transaction
// i_in      in   op, index, value                          i_in.valid & i_in.ready
// o_out     out  channel, coef_re, coef_im, last, status   o_out.valid & o_out.ready
// i_cfg_*   in   register index, data                      i_cfg_we, no wait
//
// Tap and sample loads are accepted only in the idle state.
// A frame does a read-modify-write of the fold memory for each window tap, then
// one MAC per (m, k) pair of the DFT.
// The first frame after reset or after a channels write also builds the twiddle
// table in the serial divider and sine unit.
// Reset clears control state only; the stores need no clearing pass.
// A stalled output holds its item; work stops while the next result cannot be taken.
module gabor_frame_transform import gft_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gft_in_if.sink                i_in,
    gft_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state   r_state, n_state;
    t_div_job r_job, n_job;

    logic [HOP_W-1:0] r_hop;
    logic [CHN_W-1:0] r_chn;
    logic [GL_W-1:0]  r_gl;
    logic [LEN_W-1:0] r_len;
    logic             r_phase;
    logic             r_tw_ok, n_tw_ok;

    logic [24:0]      r_nh, n_nh;
    logic [LEN_W-1:0] r_dnum, n_dnum;
    logic [LEN_W-1:0] r_drem, n_drem;
    logic [LEN_W-1:0] r_den, n_den;
    logic [3:0]       r_dcnt, n_dcnt;
    logic [LEN_W-1:0] r_lmod, n_lmod;
    logic [CH_AW-1:0] r_bm, n_bm;
    logic [CH_AW-1:0] r_gm, n_gm;

    logic [SIG_AW-1:0] r_pos, n_pos;
    logic [WIN_AW-1:0] r_tap, n_tap;
    logic [CH_AW-1:0]  r_f, n_f;
    logic [GL_W-1:0]   r_l, n_l;
    logic [CHN_W-1:0]  r_k, n_k;
    logic [CHN_W-1:0]  r_m, n_m;
    logic [CH_AW-1:0]  r_j, n_j;

    logic r_v1, n_v1;
    logic r_v2;
    logic signed [56:0] r_pre, r_pim;
    logic signed [63:0] r_acc_re, n_acc_re;
    logic signed [63:0] r_acc_im, n_acc_im;
    logic signed [31:0] r_tprod;

    logic signed [VAL_W-1:0]  r_win_mem [WINDOW_DEPTH];
    logic signed [VAL_W-1:0]  r_sig_mem [SIGNAL_DEPTH];
    logic signed [FOLD_W-1:0] r_fold_mem [MAX_CHANNELS];
    logic signed [VAL_W-1:0]  r_win_q, r_sig_q;
    logic signed [FOLD_W-1:0] r_fold_q;

    logic                     r_ov, n_ov;
    logic [CH_AW-1:0]         r_och, n_och;
    logic signed [COEF_W-1:0] r_ore, n_ore;
    logic signed [COEF_W-1:0] r_oim, n_oim;
    logic                     r_olast, n_olast;
    logic                     r_ost, n_ost;

    logic                     in_acc;
    logic                     out_free;
    logic                     w_win_we, w_sig_we, w_fold_we;
    logic signed [FOLD_W-1:0] w_fold_data;
    logic [CH_AW-1:0]         w_fold_waddr;
    logic [CH_AW-1:0]         fold_raddr;
    logic                     tw_start, tw_busy;
    t_twiddle                 tw_q;

    logic [LEN_W:0]   rem_sh;
    logic             dge;
    logic             cfg_good;
    logic [7:0]       glh;
    logic [LEN_W:0]   pos_s;
    logic [LEN_W-1:0] pos_n;
    logic [GL_W-1:0]  tap_n;
    logic [CHN_W-1:0] f_n;
    logic [CHN_W-1:0] f0_s;
    logic [GL_W-1:0]  tap0_s;
    logic [CHN_W-1:0] j_s;

    function automatic logic signed [COEF_W-1:0] round_sat(input logic signed [63:0] acc);
        logic signed [63:0] t;
        t = (acc + 64'sd16384) >>> 15;
        if (t > 64'sd549755813887) begin
            return 40'sh7F_FFFF_FFFF;
        end
        if (t < -64'sd549755813888) begin
            return 40'sh80_0000_0000;
        end
        return t[COEF_W-1:0];
    endfunction

    gft_twiddle u_twiddle (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (tw_start),
        .i_channels (r_chn),
        .o_busy     (tw_busy),
        .i_rd_addr  (r_j),
        .o_rd_data  (tw_q)
    );

    assign i_in.ready    = (r_state == S_IDLE);
    assign in_acc        = i_in.valid && i_in.ready;
    assign out_free      = !r_ov || o_out.ready;
    assign o_out.valid   = r_ov;
    assign o_out.channel = r_och;
    assign o_out.coef_re = r_ore;
    assign o_out.coef_im = r_oim;
    assign o_out.last    = r_olast;
    assign o_out.status  = r_ost;

    assign glh        = r_gl[GL_W-1:1];
    assign fold_raddr = (r_state == S_DFT) ? r_k[CH_AW-1:0] : r_f;

    always_comb begin
        n_state  = r_state;
        n_job    = r_job;
        n_tw_ok  = r_tw_ok;
        n_nh     = r_nh;
        n_dnum   = r_dnum;
        n_drem   = r_drem;
        n_den    = r_den;
        n_dcnt   = r_dcnt;
        n_lmod   = r_lmod;
        n_bm     = r_bm;
        n_gm     = r_gm;
        n_pos    = r_pos;
        n_tap    = r_tap;
        n_f      = r_f;
        n_l      = r_l;
        n_k      = r_k;
        n_m      = r_m;
        n_j      = r_j;
        n_v1     = 1'b0;
        n_acc_re = r_acc_re;
        n_acc_im = r_acc_im;
        n_ov     = r_ov && !o_out.ready;
        n_och    = r_och;
        n_ore    = r_ore;
        n_oim    = r_oim;
        n_olast  = r_olast;
        n_ost    = r_ost;

        w_win_we     = 1'b0;
        w_sig_we     = 1'b0;
        w_fold_we    = 1'b0;
        w_fold_waddr = r_f;
        w_fold_data  = r_fold_q + FOLD_W'(r_tprod);
        tw_start     = 1'b0;

        rem_sh   = {r_drem, r_dnum[LEN_W-1]};
        dge      = (rem_sh >= {1'b0, r_den});
        cfg_good = (r_len != '0) && (32'(r_len) <= SIGNAL_DEPTH)
                && (r_hop != '0) && (r_lmod == '0)
                && (r_chn != '0) && (32'(r_chn) <= MAX_CHANNELS)
                && (r_gl != '0) && (32'(r_gl) <= WINDOW_DEPTH)
                && ({4'd0, r_gl} <= r_len)
                && (r_nh < {12'd0, r_len});
        pos_s  = {1'b0, r_nh[LEN_W-1:0]} + {1'b0, r_len} - {6'd0, glh};
        if (pos_s >= {1'b0, r_len}) begin
            pos_s = pos_s - {1'b0, r_len};
        end
        pos_n  = {1'b0, r_pos} + LEN_W'(1);
        tap_n  = {1'b0, r_tap} + GL_W'(1);
        f_n    = {1'b0, r_f} + CHN_W'(1);
        f0_s   = {1'b0, r_bm} + r_chn - {1'b0, r_gm};
        if (f0_s >= r_chn) begin
            f0_s = f0_s - r_chn;
        end
        tap0_s = r_gl - {1'b0, glh};
        if (tap0_s == r_gl) begin
            tap0_s = '0;
        end
        j_s    = {1'b0, r_j} + r_m;
        if (j_s >= r_chn) begin
            j_s = j_s - r_chn;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (t_op'(i_in.op))
                        OP_TAP: begin
                            w_win_we = (32'(i_in.index) < WINDOW_DEPTH);
                        end
                        OP_SAMPLE: begin
                            w_sig_we = (32'(i_in.index) < SIGNAL_DEPTH);
                        end
                        OP_FRAME: begin
                            n_nh    = 25'(i_in.index * r_hop);
                            n_job   = DIV_LEN;
                            n_dnum  = r_len;
                            n_den   = r_hop;
                            n_drem  = '0;
                            n_dcnt  = '0;
                            n_state = S_DIV;
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                n_drem = dge ? LEN_W'(rem_sh - {1'b0, r_den}) : LEN_W'(rem_sh);
                n_dnum = r_dnum << 1;
                n_dcnt = r_dcnt + 4'd1;
                if (32'(r_dcnt) == LEN_W - 1) begin
                    n_drem = '0;
                    n_dcnt = '0;
                    n_den  = {{(LEN_W-CHN_W){1'b0}}, r_chn};
                    case (r_job)
                        DIV_LEN: begin
                            n_lmod  = dge ? LEN_W'(rem_sh - {1'b0, r_den}) : LEN_W'(rem_sh);
                            n_state = S_EVAL;
                        end
                        DIV_BASE: begin
                            n_bm   = dge ? CH_AW'(rem_sh - {1'b0, r_den}) : CH_AW'(rem_sh);
                            n_job  = DIV_GLH;
                            n_dnum = {5'd0, glh};
                        end
                        default: begin
                            n_gm    = dge ? CH_AW'(rem_sh - {1'b0, r_den}) : CH_AW'(rem_sh);
                            n_state = S_SETUP;
                        end
                    endcase
                end
            end
            S_EVAL: begin
                if (!cfg_good) begin
                    n_state = S_ERR;
                end else begin
                    n_job   = DIV_BASE;
                    n_dnum  = r_phase ? '0 : r_nh[LEN_W-1:0];
                    n_den   = {{(LEN_W-CHN_W){1'b0}}, r_chn};
                    n_drem  = '0;
                    n_dcnt  = '0;
                    n_state = S_DIV;
                end
            end
            S_ERR: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_och   = '0;
                    n_ore   = '0;
                    n_oim   = '0;
                    n_olast = 1'b1;
                    n_ost   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SETUP: begin
                n_pos   = pos_s[SIG_AW-1:0];
                n_tap   = tap0_s[WIN_AW-1:0];
                n_f     = f0_s[CH_AW-1:0];
                n_l     = '0;
                n_k     = '0;
                n_state = r_tw_ok ? S_CLR : S_TWGO;
            end
            S_TWGO: begin
                tw_start = 1'b1;
                n_state  = S_TWWAIT;
            end
            S_TWWAIT: begin
                if (!tw_busy) begin
                    n_tw_ok = 1'b1;
                    n_state = S_CLR;
                end
            end
            S_CLR: begin
                w_fold_we    = 1'b1;
                w_fold_waddr = r_k[CH_AW-1:0];
                w_fold_data  = '0;
                n_k          = r_k + CHN_W'(1);
                if (r_k == r_chn - CHN_W'(1)) begin
                    n_state = S_TAPA;
                end
            end
            S_TAPA: n_state = S_TAPB;
            S_TAPB: n_state = S_TAPC;
            S_TAPC: begin
                // accumulate this product, then advance sample, tap and fold bin
                w_fold_we = 1'b1;
                n_pos = (pos_n == r_len) ? '0 : pos_n[SIG_AW-1:0];
                n_tap = (tap_n == r_gl) ? '0 : tap_n[WIN_AW-1:0];
                n_f   = (f_n == r_chn) ? '0 : f_n[CH_AW-1:0];
                n_l   = r_l + GL_W'(1);
                if (r_l == r_gl - GL_W'(1)) begin
                    n_m      = '0;
                    n_k      = '0;
                    n_j      = '0;
                    n_acc_re = '0;
                    n_acc_im = '0;
                    n_state  = S_DFT;
                end else begin
                    n_state = S_TAPA;
                end
            end
            S_DFT: begin
                n_v1 = 1'b1;
                n_k  = r_k + CHN_W'(1);
                n_j  = j_s[CH_AW-1:0];
                if (r_k == r_chn - CHN_W'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ov     = 1'b1;
                    n_och    = r_m[CH_AW-1:0];
                    n_ore    = round_sat(r_acc_re);
                    n_oim    = round_sat(r_acc_im);
                    n_olast  = (r_m == r_chn - CHN_W'(1));
                    n_ost    = 1'b0;
                    n_m      = r_m + CHN_W'(1);
                    n_k      = '0;
                    n_j      = '0;
                    n_acc_re = '0;
                    n_acc_im = '0;
                    n_state  = (r_m == r_chn - CHN_W'(1)) ? S_IDLE : S_DFT;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (r_v2) begin
            n_acc_re = r_acc_re + 64'(r_pre);
            n_acc_im = r_acc_im - 64'(r_pim);
        end
        if (i_cfg_we && (t_cfg_idx'(i_cfg_idx) == CFG_CHANNELS)) begin
            n_tw_ok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hop   <= HOP_W'(1);
            r_chn   <= CHN_W'(64);
            r_gl    <= GL_W'(256);
            r_len   <= LEN_W'(4096);
            r_phase <= 1'b0;
            r_tw_ok <= 1'b0;
            r_ov    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tw_ok <= n_tw_ok;
            r_ov    <= n_ov;
            r_v1    <= n_v1;
            r_v2    <= r_v1;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_HOP:        r_hop   <= i_cfg_data[HOP_W-1:0];
                    CFG_CHANNELS:   r_chn   <= i_cfg_data[CHN_W-1:0];
                    CFG_WINDOW_LEN: r_gl    <= i_cfg_data[GL_W-1:0];
                    CFG_SIGNAL_LEN: r_len   <= i_cfg_data[LEN_W-1:0];
                    CFG_PHASE_MODE: r_phase <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        r_job    <= n_job;
        r_nh     <= n_nh;
        r_dnum   <= n_dnum;
        r_drem   <= n_drem;
        r_den    <= n_den;
        r_dcnt   <= n_dcnt;
        r_lmod   <= n_lmod;
        r_bm     <= n_bm;
        r_gm     <= n_gm;
        r_pos    <= n_pos;
        r_tap    <= n_tap;
        r_f      <= n_f;
        r_l      <= n_l;
        r_k      <= n_k;
        r_m      <= n_m;
        r_j      <= n_j;
        r_acc_re <= n_acc_re;
        r_acc_im <= n_acc_im;
        r_pre    <= r_fold_q * tw_q.cos_v;
        r_pim    <= r_fold_q * tw_q.sin_v;
        r_tprod  <= r_sig_q * r_win_q;
        r_och    <= n_och;
        r_ore    <= n_ore;
        r_oim    <= n_oim;
        r_olast  <= n_olast;
        r_ost    <= n_ost;
    end

    always_ff @(posedge i_clk) begin
        if (w_win_we) begin
            r_win_mem[i_in.index[WIN_AW-1:0]] <= i_in.value;
        end
        r_win_q <= r_win_mem[r_tap];
    end

    always_ff @(posedge i_clk) begin
        if (w_sig_we) begin
            r_sig_mem[i_in.index[SIG_AW-1:0]] <= VAL_W'($signed(i_in.value[SAMPLE_WIDTH-1:0]));
        end
        r_sig_q <= r_sig_mem[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (w_fold_we) begin
            r_fold_mem[w_fold_waddr] <= w_fold_data;
        end
        r_fold_q <= r_fold_mem[fold_raddr];
    end

endmodule

FILE: rtl/gft_twiddle.sv
module gft_twiddle import gft_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [CHN_W-1:0] i_channels,
    output logic             o_busy,
    input  logic [CH_AW-1:0] i_rd_addr,
    output t_twiddle         o_rd_data
);

    t_tw_state   r_state, n_state;
    logic [CHN_W-1:0] r_j, n_j;
    logic [5:0]  r_cnt, n_cnt;
    logic [37:0] r_num, n_num;
    logic [CHN_W-1:0] r_rem, n_rem;
    logic [31:0] r_u, n_u;
    logic        r_second, n_second;
    logic [2:0]  r_step, n_step;
    logic [30:0] r_x, n_x;
    logic [30:0] r_x2, n_x2;
    logic        r_neg, n_neg;
    logic [61:0] r_prod, n_prod;
    logic signed [TW_W-1:0] r_sin, n_sin;

    t_twiddle    r_mem [MAX_CHANNELS];
    t_twiddle    r_rd_q;
    logic        w_we;
    t_twiddle    w_wdata;

    logic [CHN_W:0]  rem_sh;
    logic            ge;
    logic [30:0]     opa, opb;
    logic [31:0]     hi;
    logic [31:0]     ang;
    logic [32:0]     s_rnd;
    logic [TW_W-1:0] s_cap;
    logic signed [TW_W-1:0] s_val;

    function automatic logic [30:0] fold_x(input logic [31:0] a);
        if (a[30]) begin
            return 31'h4000_0000 - {1'b0, a[29:0]};
        end
        return {1'b0, a[29:0]};
    endfunction

    assign o_busy    = (r_state != TW_IDLE);
    assign o_rd_data = r_rd_q;

    always_comb begin
        n_state  = r_state;
        n_j      = r_j;
        n_cnt    = r_cnt;
        n_num    = r_num;
        n_rem    = r_rem;
        n_u      = r_u;
        n_second = r_second;
        n_step   = r_step;
        n_x      = r_x;
        n_x2     = r_x2;
        n_neg    = r_neg;
        n_prod   = r_prod;
        n_sin    = r_sin;
        w_we     = 1'b0;
        hi       = r_prod[61:30];
        opa      = r_x;
        opb      = r_x;
        ang      = r_u + 32'h4000_0000;
        s_rnd    = ({1'b0, hi} + 33'd16384) >> 15;
        s_cap    = (s_rnd > 33'd32768) ? TW_W'(32768) : s_rnd[TW_W-1:0];
        s_val    = r_neg ? -$signed(s_cap) : $signed(s_cap);
        w_wdata  = '{sin_v: r_sin, cos_v: s_val};
        rem_sh   = {r_rem, r_num[37]};
        ge       = (rem_sh >= {1'b0, i_channels});

        case (r_state)
            TW_IDLE: begin
                if (i_start) begin
                    n_j     = '0;
                    n_num   = '0;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = TW_DIV;
                end
            end
            TW_DIV: begin
                // shift quotient bits in from the bottom of the dividend
                n_rem = ge ? CHN_W'(rem_sh - {1'b0, i_channels}) : CHN_W'(rem_sh);
                n_num = {r_num[36:0], ge};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd37) begin
                    n_u      = n_num[31:0];
                    n_second = 1'b0;
                    n_x      = fold_x(n_num[31:0]);
                    n_neg    = n_num[31];
                    n_step   = '0;
                    n_state  = TW_SIN;
                end
            end
            TW_SIN: begin
                case (r_step)
                    3'd0: begin
                        opa = r_x;
                        opb = r_x;
                    end
                    3'd1: begin
                        opa  = hi[30:0];
                        opb  = SIN_C9;
                        n_x2 = hi[30:0];
                    end
                    3'd2: begin
                        opa = r_x2;
                        opb = 31'({1'b0, SIN_C7} - hi);
                    end
                    3'd3: begin
                        opa = r_x2;
                        opb = 31'({1'b0, SIN_C5} - hi);
                    end
                    3'd4: begin
                        opa = r_x2;
                        opb = 31'({1'b0, SIN_C3} - hi);
                    end
                    3'd5: begin
                        opa = r_x;
                        opb = 31'({1'b0, SIN_C1} - hi);
                    end
                    default: begin
                        opa = r_x;
                        opb = r_x;
                    end
                endcase
                n_prod = opa * opb;
                n_step = r_step + 3'd1;
                if (r_step == 3'd6) begin
                    if (!r_second) begin
                        // run again a quarter turn later for the cosine
                        n_sin    = s_val;
                        n_second = 1'b1;
                        n_x      = fold_x(ang);
                        n_neg    = ang[31];
                        n_step   = '0;
                    end else begin
                        w_we = 1'b1;
                        n_j  = r_j + CHN_W'(1);
                        if (r_j == i_channels - CHN_W'(1)) begin
                            n_state = TW_IDLE;
                        end else begin
                            n_num   = {n_j[CH_AW-1:0], 32'h0};
                            n_rem   = '0;
                            n_cnt   = '0;
                            n_state = TW_DIV;
                        end
                    end
                end
            end
            default: n_state = TW_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TW_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_j      <= n_j;
        r_cnt    <= n_cnt;
        r_num    <= n_num;
        r_rem    <= n_rem;
        r_u      <= n_u;
        r_second <= n_second;
        r_step   <= n_step;
        r_x      <= n_x;
        r_x2     <= n_x2;
        r_neg    <= n_neg;
        r_prod   <= n_prod;
        r_sin    <= n_sin;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_j[CH_AW-1:0]] <= w_wdata;
        end
        r_rd_q <= r_mem[i_rd_addr];
    end

endmodule
